FILE: hdl/lfu_pkg.sv
`default_nettype none
package lfu_pkg;
  localparam int unsigned EntriesDef = 16;
  localparam int unsigned KeyBitsDef = 32;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned CapBits = 5;
  localparam logic [CapBits-1:0] CapReset = 5'd16;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture request, start lookup
    logic scan;     // one victim-search step
    logic evict;    // remove victim
    logic commit;   // apply hit update or insert
  } lfu_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_done;
  } lfu_sts_t;
endpackage
`default_nettype wire

FILE: hdl/lfu_ctrl.sv
`default_nettype none
module lfu_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire lfu_pkg::lfu_sts_t sts_i,
  output lfu_pkg::lfu_cmd_t    cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StEvict = 3'd2;
  localparam logic [2:0] StCommit = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = StEvict;
      end
      StEvict: begin
        cmd_o.evict = 1'b1;
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/lfu_dpath.sv
`default_nettype none
module lfu_dpath #(
  parameter int unsigned Entries = lfu_pkg::EntriesDef,
  parameter int unsigned KeyBits = lfu_pkg::KeyBitsDef,
  parameter int unsigned ValueBits = lfu_pkg::ValueBitsDef,
  parameter int unsigned CountBits = lfu_pkg::CountBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lfu_pkg::lfu_cmd_t       cmd_i,
  output lfu_pkg::lfu_sts_t            sts_o,
  input  wire logic [lfu_pkg::CapBits-1:0] cap_i,
  input  wire logic                    put_i,
  input  wire logic [KeyBits-1:0]      key_i,
  input  wire logic [ValueBits-1:0]    val_i,
  output logic                         hit_o,
  output logic [ValueBits-1:0]         rd_o,
  output logic                         ev_o,
  output logic [KeyBits-1:0]           evk_o
);
  localparam int unsigned IdxBits = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned OccBits = $clog2(Entries + 1);
  localparam int unsigned CmpBits = (OccBits > lfu_pkg::CapBits) ? OccBits : lfu_pkg::CapBits;
  localparam logic [CountBits-1:0] CountMax = '1;

  logic [Entries-1:0]   vld_q;
  logic [KeyBits-1:0]   key_q [Entries];
  logic [ValueBits-1:0] val_q [Entries];
  logic [CountBits-1:0] cnt_q [Entries];
  logic [IdxBits-1:0]   rnk_q [Entries];
  logic [OccBits-1:0]   occ_q;

  logic                 put_q;
  logic [KeyBits-1:0]   rkey_q;
  logic [ValueBits-1:0] rval_q;
  logic                 hit_q;
  logic [IdxBits-1:0]   hidx_q;
  logic                 vfound_q;
  logic [IdxBits-1:0]   vidx_q;
  logic [IdxBits-1:0]   scan_q;
  logic                 ev_q;
  logic [KeyBits-1:0]   evk_q;
  logic [ValueBits-1:0] rd_q;

  // associative match on the incoming key
  logic [Entries-1:0] match;
  logic               mhit;
  logic [IdxBits-1:0] midx;
  always_comb begin
    mhit = 1'b0;
    midx = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = vld_q[i] && (key_q[i] == key_i);
    end
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        mhit = 1'b1;
        midx = IdxBits'(i);
      end
    end
  end

  // clamp capacity to the entry count
  logic [CmpBits-1:0] cap_c;
  logic               cap_zero, full;
  always_comb begin
    cap_c = (CmpBits'(cap_i) > CmpBits'(Entries)) ? CmpBits'(Entries) : CmpBits'(cap_i);
    cap_zero = (cap_i == '0);
    full = CmpBits'(occ_q) >= cap_c;
  end

  // victim candidate test for the scanned entry
  logic better;
  always_comb begin
    better = vld_q[scan_q] && (!vfound_q || (cnt_q[scan_q] < cnt_q[vidx_q]) ||
             ((cnt_q[scan_q] == cnt_q[vidx_q]) && (rnk_q[scan_q] > rnk_q[vidx_q])));
  end
  assign sts_o.scan_done = (scan_q == IdxBits'(Entries - 1));

  // first free slot after eviction
  logic               free_any;
  logic [IdxBits-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxBits'(i);
      end
    end
  end

  logic do_evict;
  assign do_evict = put_q && !cap_zero && !hit_q && full && vfound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      occ_q <= '0;
    end else if (cmd_i.evict && do_evict) begin
      vld_q[vidx_q] <= 1'b0;
      occ_q <= occ_q - OccBits'(1);
    end else if (cmd_i.commit && put_q && !cap_zero && !hit_q && free_any) begin
      vld_q[free_idx] <= 1'b1;
      occ_q <= occ_q + OccBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      put_q    <= put_i;
      rkey_q   <= key_i;
      rval_q   <= val_i;
      hit_q    <= mhit;
      hidx_q   <= midx;
      rd_q     <= (!put_i && mhit) ? val_q[midx] : '0;
      vfound_q <= 1'b0;
      vidx_q   <= '0;
      scan_q   <= '0;
      ev_q     <= 1'b0;
      evk_q    <= '0;
    end
    if (cmd_i.scan) begin
      if (better) begin
        vfound_q <= 1'b1;
        vidx_q   <= scan_q;
      end
      if (!sts_o.scan_done) scan_q <= scan_q + IdxBits'(1);
    end
    if (cmd_i.evict && do_evict) begin
      ev_q  <= 1'b1;
      evk_q <= key_q[vidx_q];
      for (int i = 0; i < Entries; i++) begin
        if (vld_q[i] && rnk_q[i] > rnk_q[vidx_q]) rnk_q[i] <= rnk_q[i] - IdxBits'(1);
      end
    end
    if (cmd_i.commit) begin
      if (hit_q && (!put_q || !cap_zero)) begin
        if (put_q) val_q[hidx_q] <= rval_q;
        if (cnt_q[hidx_q] != CountMax) cnt_q[hidx_q] <= cnt_q[hidx_q] + CountBits'(1);
        for (int i = 0; i < Entries; i++) begin
          if (vld_q[i] && IdxBits'(i) != hidx_q && rnk_q[i] < rnk_q[hidx_q])
            rnk_q[i] <= rnk_q[i] + IdxBits'(1);
        end
        rnk_q[hidx_q] <= '0;
      end else if (put_q && !cap_zero && !hit_q && free_any) begin
        for (int i = 0; i < Entries; i++) begin
          if (vld_q[i]) rnk_q[i] <= rnk_q[i] + IdxBits'(1);
        end
        key_q[free_idx] <= rkey_q;
        val_q[free_idx] <= rval_q;
        cnt_q[free_idx] <= CountBits'(1);
        rnk_q[free_idx] <= '0;
      end
    end
  end

  assign hit_o = hit_q;
  assign rd_o  = rd_q;
  assign ev_o  = ev_q;
  assign evk_o = evk_q;
endmodule
`default_nettype wire

FILE: hdl/lfu_cache_replacement_unit.sv
`default_nettype none
// LFU cache replacement unit with least-recently-used tie break.
// Input stream (s_axis): one transaction per request; tdata carries the
// command (get 0, put 1), key and write value. Output stream (m_axis): one
// transaction per request with hit, read value, evicted flag and victim key.
// Configuration: cfg_we_i writes capacity_in_use (entries allowed, 0 turns
// puts off); change it only while the unit is idle and the store empty.
// Timing: a request is captured, then the victim search walks one entry per
// cycle over all ENTRIES slots (count, then rank compare), followed by an
// evict step and a commit step. One request is in flight at a time.
// Reset clears all valid bits and the occupancy count; capacity returns to 16.
// When the receiver stalls, hold the result on m_axis and accept no new
// request until the result transaction completes.
module lfu_cache_replacement_unit #(
  parameter int unsigned Entries = lfu_pkg::EntriesDef,
  parameter int unsigned KeyBits = lfu_pkg::KeyBitsDef,
  parameter int unsigned ValueBits = lfu_pkg::ValueBitsDef,
  parameter int unsigned CountBits = lfu_pkg::CountBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [lfu_pkg::CapBits-1:0] cfg_wdata_i,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // [0] command, [32:1] lookup_key, [64:33] write_value, zero padded
  input  wire logic [71:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key, zero padded
  output logic [71:0] m_axis_tdata
);
  lfu_pkg::lfu_cmd_t cmd;
  lfu_pkg::lfu_sts_t sts;
  logic [lfu_pkg::CapBits-1:0] cap_q;
  logic hit, ev;
  logic [ValueBits-1:0] rd;
  logic [KeyBits-1:0] evk;

  // hold capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  lfu_dpath #(.Entries(Entries), .KeyBits(KeyBits), .ValueBits(ValueBits),
              .CountBits(CountBits)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cap_i(cap_q),
    .put_i(s_axis_tdata[0]), .key_i(s_axis_tdata[KeyBits:1]),
    .val_i(s_axis_tdata[KeyBits+ValueBits:KeyBits+1]),
    .hit_o(hit), .rd_o(rd), .ev_o(ev), .evk_o(evk)
  );

  assign m_axis_tdata = {6'd0, evk, ev, rd, hit};
endmodule
`default_nettype wire

FILE: hdl/lfu_checker.sv
`default_nettype none
module lfu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);
  // one request at a time: never ready while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
  // accepted request yields no result next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early result");
  // read value only with hit
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
    else $error("read value without hit");
  // eviction never on a hit
  a_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[33])) else $error("evict on hit");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");
endmodule

bind lfu_cache_replacement_unit lfu_checker u_lfu_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

FILE: sim/tb_lfu_cache_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_lfu_cache_replacement_unit;
  localparam int unsigned Slots = lfu_pkg::EntriesDef;
  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;
  localparam int unsigned CountMax = 16'hFFFF;
  // Per-request latency of the unit plus slack.
  localparam int unsigned DrainCycles = 40;
  localparam longint unsigned CycleLimit = 2000000;
  localparam int unsigned RspDepth = 64;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lfu_rsp_t;

  // Expected-response store for the LFU unit: holds predicted outputs in order.
  class lfu_response_board;
    lfu_rsp_t rsp_ring[RspDepth];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned mismatches;

    function int unsigned pending();
      return wr_ptr - rd_ptr;
    endfunction

    function void note_request(lfu_rsp_t rsp);
      rsp_ring[wr_ptr % RspDepth] = rsp;
      wr_ptr++;
    endfunction

    function void check_response(logic [71:0] tdata);
      lfu_rsp_t want;
      lfu_rsp_t got;
      got.hit = tdata[0];
      got.read_value = tdata[32:1];
      got.evicted = tdata[33];
      got.evicted_key = tdata[65:34];
      if (pending() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", tdata);
        return;
      end
      want = rsp_ring[rd_ptr % RspDepth];
      rd_ptr++;
      if (want != got || tdata[71:66] != '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit=%0b rd=%h ev=%0b evk=%h, got hit=%0b rd=%h ev=%0b evk=%h",
                   want.hit, want.read_value, want.evicted, want.evicted_key,
                   got.hit, got.read_value, got.evicted, got.evicted_key);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  lfu_cache_replacement_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  lfu_response_board board = new();

  // Shadow copy of the store used to predict each response.
  logic        slot_valid[Slots];
  logic [31:0] slot_key[Slots];
  logic [31:0] slot_value[Slots];
  logic [15:0] slot_uses[Slots];
  int unsigned slot_age[Slots];
  int unsigned fill_level;
  int unsigned capacity;

  int unsigned idle_pct;   // sender idle chance, percent
  int unsigned stall_pct;  // receiver stall chance, percent
  longint unsigned cycle_count;
  logic [31:0] key_pool[8];

  // Move slot e to the front of the recency order.
  function automatic void touch_slot(int e);
    for (int i = 0; i < Slots; i++)
      if (slot_valid[i] && i != e && slot_age[i] < slot_age[e]) slot_age[i]++;
    slot_age[e] = 0;
  endfunction

  function automatic lfu_rsp_t predict_access(logic cmd, logic [31:0] key, logic [31:0] val);
    lfu_rsp_t rsp;
    int found;
    int victim;
    int free_slot;
    int unsigned cap;
    found = -1;
    victim = -1;
    free_slot = -1;
    cap = (capacity > Slots) ? Slots : capacity;
    rsp = '0;
    for (int i = 0; i < Slots; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    rsp.hit = (found >= 0);
    if (cmd == CmdGet) begin
      if (found >= 0) begin
        rsp.read_value = slot_value[found];
        if (slot_uses[found] != CountMax) slot_uses[found]++;
        touch_slot(found);
      end
    end else if (cap != 0) begin
      if (found >= 0) begin
        slot_value[found] = val;
        if (slot_uses[found] != CountMax) slot_uses[found]++;
        touch_slot(found);
      end else begin
        if (fill_level >= cap) begin
          // lowest count wins, ties go to the oldest entry
          for (int i = 0; i < Slots; i++)
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          if (victim >= 0) begin
            rsp.evicted = 1'b1;
            rsp.evicted_key = slot_key[victim];
            slot_valid[victim] = 1'b0;
            fill_level--;
            for (int i = 0; i < Slots; i++)
              if (slot_valid[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
          end
        end
        for (int i = 0; i < Slots; i++)
          if (free_slot < 0 && !slot_valid[i]) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < Slots; i++) if (slot_valid[i]) slot_age[i]++;
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot] = key;
          slot_value[free_slot] = val;
          slot_uses[free_slot] = 16'd1;
          slot_age[free_slot] = 0;
          fill_level++;
        end
      end
    end
    return rsp;
  endfunction

  // Cycle watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: check each completed result transaction, stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_response(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Send one request; predict when the transaction completes, then drop valid
  // while the unit is busy anyway.
  task automatic send_request(logic cmd, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, val, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(predict_access(cmd, key, val));
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every expected result has arrived, then let the unit settle.
  task automatic drain_responses();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write capacity; only call this right after reset or when the unit has
  // been drained.
  task automatic write_capacity(logic [4:0] cap);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = cap;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom();
      default: return key_pool[$urandom_range(7)];
    endcase
  endfunction

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++)
      send_request($urandom_range(99) < 55 ? CmdPut : CmdGet, pick_key(), $urandom());
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_uses[i] = '0;
      slot_age[i] = 0;
    end
    fill_level = 0;
    capacity = 16;
    idle_pct = 0;
    stall_pct = 0;
    cycle_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Capacity zero while empty: puts are dropped, gets miss.
    write_capacity(5'd0);
    send_request(CmdPut, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CmdGet, 32'h0000_0000, 32'h0);
    drain_responses();

    // Capacity two: fill, tie on count goes to the oldest, then frequency wins.
    write_capacity(5'd2);
    send_request(CmdPut, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CmdPut, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CmdPut, 32'h1234_5678, 32'hAAAA_5555);
    send_request(CmdGet, 32'h1234_5678, 32'h0);
    send_request(CmdGet, 32'h1234_5678, 32'h0);
    send_request(CmdPut, 32'h1234_5678, 32'h5555_AAAA);
    send_request(CmdPut, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    send_request(CmdGet, 32'hDEAD_BEEF, 32'h0);
    send_request(CmdGet, 32'h0000_0000, 32'h0);
    drain_responses();

    // Lower capacity below occupancy: absent puts swap one entry each.
    write_capacity(5'd1);
    send_request(CmdPut, 32'h8000_0001, 32'h7FFF_FFFE);
    send_request(CmdGet, 32'h1234_5678, 32'h0);
    drain_responses();
    // Capacity zero with entries present: hits still reported, a put changes nothing.
    write_capacity(5'd0);
    send_request(CmdPut, 32'h8000_0001, 32'h0);
    send_request(CmdGet, 32'h8000_0001, 32'h0);
    drain_responses();
    // Capacity above the slot count behaves as full size.
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_request(CmdPut, 32'hC000_0000 + i, i);
    drain_responses();

    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    write_capacity(5'd16);
    random_phase(180, 0, 0);
    random_phase(180, 77, 0);
    // Hold off until the unit has returned every result.
    drain_responses();
    write_capacity(5'd4);
    random_phase(180, 0, 77);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    drain_responses();
    write_capacity(5'd31);
    random_phase(180, 33, 33);
    drain_responses();

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
hdl/lfu_pkg.sv
hdl/lfu_ctrl.sv
hdl/lfu_dpath.sv
hdl/lfu_cache_replacement_unit.sv
hdl/lfu_checker.sv
sim/tb_lfu_cache_replacement_unit.sv
